>>> design/qsl_pkg.sv
package qsl_pkg;

  localparam int DefMaxItems  = 64;
  localparam int DefValueBits = 32;
  localparam int CountBits    = 12;
  localparam int OutValueBits = 32;
  localparam logic [CountBits-1:0] CountMax = 12'hFFF;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_TOP,
    ST_POP,
    ST_PIVOT,
    ST_SCAN,
    ST_SWAP_W,
    ST_FINAL_W,
    ST_PUSH,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic pop;
    logic pivot_rd;
    logic scan;
    logic swap_wr;
    logic final_wr;
    logic push;
    logic out_rd;
    logic out_show;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic range_ok;
    logic scan_done;
    logic need_swap;
    logic push_done;
    logic out_last;
    logic out_taken;
  } status_t;

endpackage

>>> design/qsl_datapath.sv
module qsl_datapath
  import qsl_pkg::*;
#(
  parameter int MaxItems  = DefMaxItems,
  parameter int ValueBits = DefValueBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output status_t                      status,
  input  logic signed [ValueBits-1:0]  value,
  output logic signed [OutValueBits-1:0] sorted_value,
  output logic                         final_result,
  output logic [CountBits-1:0]         comparison_count,
  output logic [CountBits-1:0]         swap_count,
  output logic                         overflowed,
  output logic                         out_valid,
  input  logic                         out_ready
);

  localparam int IdxBits = (MaxItems > 2) ? $clog2(MaxItems) : 1;
  localparam int CntBits = $clog2(MaxItems + 1);
  localparam int SpBits  = $clog2(MaxItems + 1);

  logic [ValueBits-1:0] mem [MaxItems];
  logic [2*IdxBits-1:0] stack [MaxItems];

  logic [CntBits-1:0] item_count;
  logic [SpBits-1:0]  stack_depth;
  logic [CountBits-1:0] compare_total, swap_total;
  logic drop_flag;

  logic [IdxBits-1:0] lo, hi, k, nxt, oidx;
  logic [ValueBits-1:0] pivot, rd_k, rd_n;
  logic [2*IdxBits-1:0] top;
  logic rd_valid;
  logic push_phase;
  logic [IdxBits-1:0] q;

  logic [IdxBits-1:0] ra_addr, rb_addr;
  logic le;

  assign le = $signed(rd_k) <= $signed(pivot);

  always_comb begin
    ra_addr = k;
    rb_addr = nxt;
    if (cmd.pivot_rd) begin
      ra_addr = hi;
    end else if (cmd.out_rd) begin
      ra_addr = oidx;
    end
  end

  always_ff @(posedge clk) begin
    rd_k <= mem[ra_addr];
    rd_n <= mem[rb_addr];
    top  <= stack[stack_depth[IdxBits-1:0] - IdxBits'(1)];
    if (cmd.load && item_count < CntBits'(MaxItems)) begin
      mem[item_count[IdxBits-1:0]] <= value;
    end else if (cmd.swap_wr) begin
      mem[nxt] <= rd_k;
      mem[k]   <= rd_n;
    end else if (cmd.final_wr) begin
      mem[nxt] <= pivot;
      mem[hi]  <= rd_n;
    end
  end

  logic push_en;
  logic [2*IdxBits-1:0] push_val;
  always_comb begin
    push_en  = 1'b0;
    push_val = {lo, hi};
    if (cmd.push) begin
      if (!push_phase) begin
        push_en  = q < hi && (q + IdxBits'(1)) < hi;
        push_val = {q + IdxBits'(1), hi};
      end else begin
        push_en  = q > lo && lo < (q - IdxBits'(1));
        push_val = {lo, q - IdxBits'(1)};
      end
    end
    if (cmd.start) begin
      push_en  = item_count >= CntBits'(2);
      push_val = {IdxBits'(0), IdxBits'(item_count - CntBits'(1))};
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && stack_depth < SpBits'(MaxItems)) begin
      stack[stack_depth[IdxBits-1:0]] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      stack_depth <= '0;
      compare_total <= '0;
      swap_total <= '0;
      drop_flag <= 1'b0;
      rd_valid <= 1'b0;
      push_phase <= 1'b0;
      out_valid <= 1'b0;
      oidx <= '0;
    end else begin
      if (cmd.load) begin
        if (item_count < CntBits'(MaxItems)) begin
          item_count <= item_count + CntBits'(1);
        end else begin
          drop_flag <= 1'b1;
        end
      end
      if (push_en && stack_depth < SpBits'(MaxItems)) begin
        stack_depth <= stack_depth + SpBits'(1);
      end
      if (cmd.pop) begin
        stack_depth <= stack_depth - SpBits'(1);
        lo <= top[2*IdxBits-1:IdxBits];
        hi <= top[IdxBits-1:0];
      end
      if (cmd.pivot_rd) begin
        k <= lo;
        nxt <= lo;
        rd_valid <= 1'b0;
        push_phase <= 1'b0;
      end
      if (cmd.scan) begin
        if (!rd_valid) begin
          rd_valid <= 1'b1;
          if (k == lo) begin
            pivot <= rd_k;
          end
        end
      end
      if (cmd.scan && rd_valid && !status.scan_done) begin
        if (compare_total != CountMax) compare_total <= compare_total + 1'b1;
        if (le) begin
          rd_valid <= 1'b0;
        end else begin
          k <= k + IdxBits'(1);
          rd_valid <= 1'b0;
        end
      end
      if (cmd.swap_wr) begin
        if (swap_total != CountMax) swap_total <= swap_total + 1'b1;
        nxt <= nxt + IdxBits'(1);
        k <= k + IdxBits'(1);
        rd_valid <= 1'b0;
      end
      if (cmd.final_wr) begin
        if (swap_total != CountMax) swap_total <= swap_total + 1'b1;
        q <= nxt;
      end
      if (cmd.push) begin
        push_phase <= ~push_phase;
      end
      if (cmd.out_rd) begin
        out_valid <= 1'b0;
      end
      if (cmd.out_show) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
          sorted_value <= OutValueBits'($signed(rd_k));
          final_result <= (CntBits'(oidx) + CntBits'(1)) == item_count;
          comparison_count <= compare_total;
          swap_count <= swap_total;
          overflowed <= drop_flag;
        end else if (out_ready) begin
          out_valid <= 1'b0;
          oidx <= oidx + IdxBits'(1);
        end
      end
      if (cmd.clear) begin
        item_count <= '0;
        stack_depth <= '0;
        compare_total <= '0;
        swap_total <= '0;
        drop_flag <= 1'b0;
        oidx <= '0;
      end
    end
  end

  // Scan compares only once the read of element k has landed; when it is
  // not greater than the pivot a swap write follows, else k moves on.
  assign status.stack_empty = stack_depth == '0;
  assign status.range_ok    = CntBits'(hi) < item_count && lo < hi;
  assign status.scan_done   = rd_valid ? 1'b0 : (k == hi);
  assign status.need_swap   = rd_valid && !status.scan_done && le;
  assign status.push_done   = push_phase;
  assign status.out_last    = (CntBits'(oidx) + CntBits'(1)) >= item_count;
  assign status.out_taken   = out_valid && out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CntBits'(MaxItems)) else $error("item count beyond capacity");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= SpBits'(MaxItems)) else $error("range stack overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sorted_value))
    else $error("result dropped while stalled");

endmodule

>>> design/qsl_ctrl.sv
module qsl_ctrl
  import qsl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    last_item,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:    if (in_valid && last_item) state_next = ST_START;
      ST_START:   state_next = ST_TOP;
      ST_TOP:     state_next = ST_POP;
      ST_POP:     state_next = status.stack_empty ? ST_OUT_RD : ST_PIVOT;
      ST_PIVOT:   state_next = status.range_ok ? ST_SCAN : ST_POP;
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_FINAL_W;
        end else if (status.need_swap) begin
          state_next = ST_SWAP_W;
        end
      end
      ST_SWAP_W:  state_next = ST_SCAN;
      ST_FINAL_W: state_next = ST_PUSH;
      ST_PUSH:    if (status.push_done) state_next = ST_TOP;
      ST_OUT_RD:  state_next = ST_OUT_SHOW;
      ST_OUT_SHOW: begin
        if (status.out_taken) begin
          state_next = status.out_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_START:    cmd.start = 1'b1;
      ST_POP:      cmd.pop = !status.stack_empty;
      ST_PIVOT:    cmd.pivot_rd = 1'b1;
      ST_SCAN:     cmd.scan = 1'b1;
      ST_SWAP_W:   cmd.swap_wr = 1'b1;
      ST_FINAL_W:  cmd.final_wr = 1'b1;
      ST_PUSH:     cmd.push = 1'b1;
      ST_OUT_RD:   cmd.out_rd = 1'b1;
      ST_OUT_SHOW: begin
        cmd.out_show = 1'b1;
        cmd.clear = status.out_taken && status.out_last;
      end
      default:     cmd = '0;
    endcase
  end

  a_load_only: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_LOAD) else $error("load outside loading phase");
  a_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD && in_valid && last_item |=> state == ST_START)
    else $error("sort did not start");
  a_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.swap_wr, cmd.final_wr, cmd.out_rd}))
    else $error("conflicting commands");

endmodule

>>> design/quicksort_lomuto_counted_core.sv
// Channel  Signals                                      Direction
// input    in_valid, in_ready, value, last_item         into block
// output   out_valid, out_ready, sorted_value,          out of block
//          final_result, comparison_count, swap_count, overflowed
//
// While loading, every offered beat is taken. After the beat marked last
// the block sorts in place, range by range, with each exchange writing
// the element memory at two addresses.
// Each result is then read from memory and held on the output until taken.
// Reset clears counts and state; no input is taken while sorting or emitting.
module quicksort_lomuto_counted_core
  import qsl_pkg::*;
#(
  parameter int MaxItems  = DefMaxItems,
  parameter int ValueBits = DefValueBits
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ValueBits-1:0]    value,
  input  logic                           last_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [OutValueBits-1:0] sorted_value,
  output logic                           final_result,
  output logic [CountBits-1:0]           comparison_count,
  output logic [CountBits-1:0]           swap_count,
  output logic                           overflowed
);

  cmd_t    cmd;
  status_t status;

  qsl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .last_item, .in_ready, .status, .cmd
  );

  qsl_datapath #(.MaxItems(MaxItems), .ValueBits(ValueBits)) u_dp (
    .clk, .rst, .cmd, .status, .value, .sorted_value, .final_result,
    .comparison_count, .swap_count, .overflowed, .out_valid, .out_ready
  );

endmodule

>>> verif/qsl_checker.sv
`timescale 1ns / 100ps

module qsl_checker
  import qsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [31:0]      value,
  input  logic                    last_item,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [31:0]      sorted_value,
  input  logic                    final_result,
  input  logic [CountBits-1:0]    comparison_count,
  input  logic [CountBits-1:0]    swap_count,
  input  logic                    overflowed,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic signed [31:0]   val;
    logic                 fin;
    logic [CountBits-1:0] cmp;
    logic [CountBits-1:0] swp;
    logic                 ovf;
  } sorted_beat_t;

  sorted_beat_t sorted_q[$];
  logic signed [31:0] batch[DefMaxItems];
  int batch_len;
  logic batch_dropped;
  int cmp_tot;
  int swp_tot;

  function automatic void bump_count(ref int c);
    if (c < CountMax) c++;
  endfunction

  task automatic swap_elems(int a, int b);
    logic signed [31:0] t;
    t = batch[a];
    batch[a] = batch[b];
    batch[b] = t;
    bump_count(swp_tot);
  endtask

  task automatic sort_batch();
    int lo_st[$];
    int hi_st[$];
    int lo, hi, nxt, piv, k;
    sorted_beat_t b;
    cmp_tot = 0;
    swp_tot = 0;
    if (batch_len >= 2) begin
      lo_st.push_back(0);
      hi_st.push_back(batch_len - 1);
    end
    while (lo_st.size() > 0) begin
      lo = lo_st.pop_back();
      hi = hi_st.pop_back();
      piv = batch[hi];
      nxt = lo;
      for (k = lo; k < hi; k++) begin
        bump_count(cmp_tot);
        if (batch[k] <= $signed(piv[31:0])) begin
          swap_elems(nxt, k);
          nxt++;
        end
      end
      swap_elems(nxt, hi);
      if (nxt + 1 < hi) begin
        lo_st.push_back(nxt + 1);
        hi_st.push_back(hi);
      end
      if (nxt > lo + 1) begin
        lo_st.push_back(lo);
        hi_st.push_back(nxt - 1);
      end
    end
    for (k = 0; k < batch_len; k++) begin
      b.val = batch[k];
      b.fin = (k + 1 == batch_len);
      b.cmp = cmp_tot[CountBits-1:0];
      b.swp = swp_tot[CountBits-1:0];
      b.ovf = batch_dropped;
      sorted_q.push_back(b);
    end
    batch_len = 0;
    batch_dropped = 0;
  endtask

  assign pending = sorted_q.size();

  always @(posedge clk) begin
    sorted_beat_t e;
    if (rst) begin
      batch_len = 0;
      batch_dropped = 0;
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          if (errors < 10) $display("unexpected result beat value=%0d", sorted_value);
          errors = errors + 1;
        end else begin
          e = sorted_q.pop_front();
          if (e.val !== sorted_value || e.fin !== final_result ||
              e.cmp !== comparison_count || e.swp !== swap_count ||
              e.ovf !== overflowed) begin
            if (errors < 10)
              $display("mismatch exp %0d/%0b/%0d/%0d/%0b got %0d/%0b/%0d/%0d/%0b",
                       e.val, e.fin, e.cmp, e.swp, e.ovf, sorted_value, final_result,
                       comparison_count, swap_count, overflowed);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (batch_len < DefMaxItems) begin
          batch[batch_len] = value;
          batch_len = batch_len + 1;
        end else begin
          batch_dropped = 1;
        end
        if (last_item) sort_batch();
      end
    end
  end

endmodule

>>> verif/tb_quicksort_lomuto_counted_core.sv
`timescale 1ns / 100ps

module tb_quicksort_lomuto_counted_core
  import qsl_pkg::*;
();

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] value = 0;
  logic last_item = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] sorted_value;
  logic final_result;
  logic [CountBits-1:0] comparison_count;
  logic [CountBits-1:0] swap_count;
  logic overflowed;
  int errors;
  int pending;
  int cycles = 0;
  int sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  quicksort_lomuto_counted_core uut (.*);

  qsl_checker chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 30);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if ((cycles / 500) % 4 == 0) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 9) < 6);
  end

  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      3: return -1;
      4: return $urandom_range(0, 7) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(logic signed [31:0] v, logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    value <= v;
    last_item <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
  endtask

  task automatic send_batch(int n, int mode);
    int k;
    for (k = 0; k < n; k++)
      send_beat(pick_value(mode < 0 ? $urandom_range(0, 6) : mode), k == n - 1);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_batch(1, 0);
    send_batch(2, 1);
    send_batch(3, 4);
    send_beat(32'sh7FFFFFFF, 0);
    send_beat(32'sh80000000, 0);
    send_beat(0, 0);
    send_beat(-1, 0);
    send_beat(5, 1);
    send_batch(4, 2);
    drain();
    repeat (50) @(posedge clk);
    send_batch(64, 5);
    send_batch(70, 4);
    while (sent < 420) begin
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 66);
      send_batch(n, -1);
      if ($urandom_range(0, 7) == 0)
        drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
